@@ rtl/scr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scr_pkg
// shared constants and codes for the sphere against capsule resolve pipeline
// ----------------------------------------------------------------------------
package scr_pkg;

   // default coordinate word width (signed fixed point, any fraction split)
   localparam int COORD_WIDTH_DEF = 32;

   // fraction bits of the segment parameter t
   localparam int T_BITS = 32;

   // how the closest point on the segment is chosen
   typedef enum logic [1:0] {
      MODE_A = 2'd0,   // clamped to the start point
      MODE_B = 2'd1,   // clamped to the end point
      MODE_T = 2'd2    // interior point from the quotient t
   } mode_type;

endpackage
`default_nettype wire

@@ rtl/scr_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scr_div
// pipelined restoring divider, one quotient bit per stage, with side payload
// ----------------------------------------------------------------------------
module scr_div #(
   parameter int DW = 8,
   parameter int QW = 8,
   parameter int PW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] in_rem,
   input  wire logic [QW-1:0] in_low,
   input  wire logic [DW-1:0] in_divisor,
   input  wire logic [PW-1:0] in_payload,
   output logic               out_valid,
   output logic [QW-1:0]      out_quot,
   output logic [PW-1:0]      out_payload
);

   logic [QW:0]   v_ff;
   logic [DW-1:0] rem_ff  [0:QW];
   logic [DW-1:0] rem_in  [0:QW];
   logic [QW-1:0] low_ff  [0:QW];
   logic [QW-1:0] low_in  [0:QW];
   logic [QW-1:0] quot_ff [0:QW];
   logic [QW-1:0] quot_in [0:QW];
   logic [DW-1:0] div_ff  [0:QW];
   logic [DW-1:0] div_in  [0:QW];
   logic [PW-1:0] pay_ff  [0:QW];
   logic [PW-1:0] pay_in  [0:QW];

   assign rem_in[0]  = in_rem;
   assign low_in[0]  = in_low;
   assign quot_in[0] = '0;
   assign div_in[0]  = in_divisor;
   assign pay_in[0]  = in_payload;

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW:0] sh;
      logic [DW:0] sub;
      logic        ge;
      // shift in next dividend bit, trial subtract
      assign sh  = {rem_ff[k], low_ff[k][QW-1]};
      assign sub = sh - {1'b0, div_ff[k]};
      assign ge  = (sh >= {1'b0, div_ff[k]});
      assign rem_in[k+1]  = ge ? sub[DW-1:0] : sh[DW-1:0];
      assign low_in[k+1]  = low_ff[k] << 1;
      assign quot_in[k+1] = (quot_ff[k] << 1) | QW'(ge);
      assign div_in[k+1]  = div_ff[k];
      assign pay_in[k+1]  = pay_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QW; k++) begin
            rem_ff[k]  <= rem_in[k];
            low_ff[k]  <= low_in[k];
            quot_ff[k] <= quot_in[k];
            div_ff[k]  <= div_in[k];
            pay_ff[k]  <= pay_in[k];
         end
      end
   end

   assign out_valid   = v_ff[QW];
   assign out_quot    = quot_ff[QW];
   assign out_payload = pay_ff[QW];

endmodule
`default_nettype wire

@@ rtl/scr_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scr_sqrt
// pipelined integer square root (floor), one root bit per stage
// ----------------------------------------------------------------------------
module scr_sqrt #(
   parameter int NW = 16,
   parameter int RW = 8,
   parameter int PW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_rad,
   input  wire logic [PW-1:0] in_payload,
   output logic               out_valid,
   output logic [RW-1:0]      out_root,
   output logic [PW-1:0]      out_payload
);

   logic [RW:0]   v_ff;
   logic [NW-1:0] rad_ff  [0:RW];
   logic [NW-1:0] rad_in  [0:RW];
   logic [RW-1:0] root_ff [0:RW];
   logic [RW-1:0] root_in [0:RW];
   logic [NW-1:0] acc_ff  [0:RW];
   logic [NW-1:0] acc_in  [0:RW];
   logic [PW-1:0] pay_ff  [0:RW];
   logic [PW-1:0] pay_in  [0:RW];

   assign rad_in[0]  = in_rad;
   assign root_in[0] = '0;
   assign acc_in[0]  = '0;
   assign pay_in[0]  = in_payload;

   for (genvar k = 0; k < RW; k++) begin : g_step
      localparam int B = RW - 1 - k;
      logic [NW+1:0] tr;
      logic          ok;
      // (root + 2^b)^2 = root^2 + root*2^(b+1) + 2^(2b)
      assign tr = {2'b00, acc_ff[k]}
                + ({{(NW+2-RW){1'b0}}, root_ff[k]} << (B + 1))
                + ((NW+2)'(1) << (2 * B));
      assign ok = (tr <= {2'b00, rad_ff[k]});
      assign acc_in[k+1]  = ok ? tr[NW-1:0] : acc_ff[k];
      assign root_in[k+1] = ok ? (root_ff[k] | (RW'(1) << B)) : root_ff[k];
      assign rad_in[k+1]  = rad_ff[k];
      assign pay_in[k+1]  = pay_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[RW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= RW; k++) begin
            rad_ff[k]  <= rad_in[k];
            root_ff[k] <= root_in[k];
            acc_ff[k]  <= acc_in[k];
            pay_ff[k]  <= pay_in[k];
         end
      end
   end

   assign out_valid   = v_ff[RW];
   assign out_root    = root_ff[RW];
   assign out_payload = pay_ff[RW];

endmodule
`default_nettype wire

@@ rtl/sphere_capsule_collision_resolve.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_capsule_collision_resolve
// sphere against capsule overlap test with push-out of the sphere centre
// ----------------------------------------------------------------------------
// usage:
//  - req_* carries one request: sphere centre and radius, capsule segment ends
//    and radius; points signed fixed point of COORD_WIDTH bits, radii unsigned
//  - rsp_* returns one result per request, in order: hit flag and the
//    corrected centre (x and y pushed out, z unchanged)
//  - a request is taken on a clock edge with valid high and stall low
//  - a request passes the 32-stage t divider, the root extraction and
//    the correction divider, each one bit per stage
//  - throughput is one request per cycle while the receiver does not stall;
//    every stage advances together; when the receiver stalls a valid result,
//    the whole pipeline holds and req_stall is raised; nothing is dropped or repeated
//  - reset clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
module sphere_capsule_collision_resolve
   import scr_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COORD_WIDTH-1:0] req_sphere_x,
   input  wire logic [COORD_WIDTH-1:0] req_sphere_y,
   input  wire logic [COORD_WIDTH-1:0] req_sphere_z,
   input  wire logic [COORD_WIDTH-2:0] req_sphere_radius,
   input  wire logic [COORD_WIDTH-1:0] req_seg_a_x,
   input  wire logic [COORD_WIDTH-1:0] req_seg_a_y,
   input  wire logic [COORD_WIDTH-1:0] req_seg_a_z,
   input  wire logic [COORD_WIDTH-1:0] req_seg_b_x,
   input  wire logic [COORD_WIDTH-1:0] req_seg_b_y,
   input  wire logic [COORD_WIDTH-1:0] req_seg_b_z,
   input  wire logic [COORD_WIDTH-2:0] req_capsule_radius,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_hit,
   output logic [COORD_WIDTH-1:0]      rsp_out_x,
   output logic [COORD_WIDTH-1:0]      rsp_out_y,
   output logic [COORD_WIDTH-1:0]      rsp_out_z
);

   localparam int W    = COORD_WIDTH;
   localparam int DENW = 2 * W + 2;    // |B-A|^2 and |P-Q|^2 widths
   localparam int RW   = W + 1;        // root width
   localparam int MW   = W + T_BITS + 1;

   // payload riding through the t divider
   typedef struct packed {
      mode_type              mode;
      logic [2:0][W-1:0]     p;
      logic [2:0][W-1:0]     a;
      logic [2:0][W-1:0]     b;
      logic [2:0][W:0]       d;
      logic [W-1:0]          rs;
   } tpay_type;

   // payload riding through the root extraction
   typedef struct packed {
      logic                  hit;
      logic                  zero;
      logic [2:0][W-1:0]     p;
      logic [1:0][W:0]       diff;
      logic [W-1:0]          rs;
   } spay_type;

   // payload riding through the correction divider
   typedef struct packed {
      logic                  hit;
      logic                  zero;
      logic [2:0][W-1:0]     p;
      logic                  neg_x;
      logic [W-1:0]          rs;
   } cpay_type;

   // saturating add of a signed offset of magnitude c to p
   function automatic logic [W-1:0] sat_add(logic [W-1:0] p, logic [W:0] c, logic neg);
      logic [W+1:0] e;
      logic [W+1:0] s;
      e = {1'b0, c};
      if (neg) begin
         e = ~e + (W+2)'(1);
      end
      s = {{2{p[W-1]}}, p} + e;
      if (s[W+1:W-1] == 3'b000 || s[W+1:W-1] == 3'b111) begin
         return s[W-1:0];
      end else if (s[W+1]) begin
         return {1'b1, {(W-1){1'b0}}};
      end else begin
         return {1'b0, {(W-1){1'b1}}};
      end
   endfunction

   logic adv;
   logic rsp_valid_ff;

   // all stages move together unless a finished result is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------------------------------------------------------- s0: capture
   logic              s0_v_ff;
   logic [2:0][W-1:0] s0_p_ff, s0_a_ff, s0_b_ff;
   logic [W-1:0]      s0_rs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_p_ff  <= {req_sphere_z, req_sphere_y, req_sphere_x};
         s0_a_ff  <= {req_seg_a_z, req_seg_a_y, req_seg_a_x};
         s0_b_ff  <= {req_seg_b_z, req_seg_b_y, req_seg_b_x};
         // summed radii, one bit wider than each radius
         s0_rs_ff <= {1'b0, req_sphere_radius} + {1'b0, req_capsule_radius};
      end
   end

   // ---------------------------------------------------------------- s1: B-A, P-A
   logic              s1_v_ff;
   logic [2:0][W-1:0] s1_p_ff, s1_a_ff, s1_b_ff;
   logic [2:0][W:0]   s1_d_ff, s1_d_in, s1_pa_ff, s1_pa_in;
   logic [W-1:0]      s1_rs_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_d_in[i]  = {s0_b_ff[i][W-1], s0_b_ff[i]} - {s0_a_ff[i][W-1], s0_a_ff[i]};
         s1_pa_in[i] = {s0_p_ff[i][W-1], s0_p_ff[i]} - {s0_a_ff[i][W-1], s0_a_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p_ff  <= s0_p_ff;
         s1_a_ff  <= s0_a_ff;
         s1_b_ff  <= s0_b_ff;
         s1_d_ff  <= s1_d_in;
         s1_pa_ff <= s1_pa_in;
         s1_rs_ff <= s0_rs_ff;
      end
   end

   // ---------------------------------------------------------------- s2: products
   logic                  s2_v_ff;
   logic [2:0][W-1:0]     s2_p_ff, s2_a_ff, s2_b_ff;
   logic [2:0][W:0]       s2_d_ff;
   logic [2:0][2*W+1:0]   s2_pd_ff, s2_pd_in, s2_dd_ff, s2_dd_in;
   logic [W-1:0]          s2_rs_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_pd_in[i] = $signed(s1_pa_ff[i]) * $signed(s1_d_ff[i]);
         s2_dd_in[i] = $signed(s1_d_ff[i]) * $signed(s1_d_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_p_ff  <= s1_p_ff;
         s2_a_ff  <= s1_a_ff;
         s2_b_ff  <= s1_b_ff;
         s2_d_ff  <= s1_d_ff;
         s2_pd_ff <= s2_pd_in;
         s2_dd_ff <= s2_dd_in;
         s2_rs_ff <= s1_rs_ff;
      end
   end

   // ---------------------------------------------------------------- s3: dot sums
   logic                s3_v_ff;
   logic [2:0][W-1:0]   s3_p_ff, s3_a_ff, s3_b_ff;
   logic [2:0][W:0]     s3_d_ff;
   logic [2*W+3:0]      s3_num_ff, s3_num_in;
   logic [DENW-1:0]     s3_den_ff, s3_den_in;
   logic [W-1:0]        s3_rs_ff;

   always_comb begin
      s3_num_in = {{2{s2_pd_ff[0][2*W+1]}}, s2_pd_ff[0]}
                + {{2{s2_pd_ff[1][2*W+1]}}, s2_pd_ff[1]}
                + {{2{s2_pd_ff[2][2*W+1]}}, s2_pd_ff[2]};
      // each square is at most 2^(2W), so the sum fits
      s3_den_in = s2_dd_ff[0] + s2_dd_ff[1] + s2_dd_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_p_ff   <= s2_p_ff;
         s3_a_ff   <= s2_a_ff;
         s3_b_ff   <= s2_b_ff;
         s3_d_ff   <= s2_d_ff;
         s3_num_ff <= s3_num_in;
         s3_den_ff <= s3_den_in;
         s3_rs_ff  <= s2_rs_ff;
      end
   end

   // ---------------------------------------------------------------- s4: clamp select
   logic            s4_v_ff;
   tpay_type        s4_pay_ff, s4_pay_in;
   logic [DENW-1:0] s4_num_ff, s4_den_ff;
   mode_type        s4_mode_in;

   always_comb begin
      // degenerate segment or projection behind A clamps to A
      if (s3_den_ff == '0 || s3_num_ff[2*W+3] || s3_num_ff == '0) begin
         s4_mode_in = MODE_A;
      end else if (s3_num_ff >= {2'b00, s3_den_ff}) begin
         s4_mode_in = MODE_B;
      end else begin
         s4_mode_in = MODE_T;
      end
      s4_pay_in.mode = s4_mode_in;
      s4_pay_in.p    = s3_p_ff;
      s4_pay_in.a    = s3_a_ff;
      s4_pay_in.b    = s3_b_ff;
      s4_pay_in.d    = s3_d_ff;
      s4_pay_in.rs   = s3_rs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_pay_ff <= s4_pay_in;
         s4_num_ff <= s3_num_ff[DENW-1:0];
         s4_den_ff <= s3_den_ff;
      end
   end

   // ---------------------------------------------------------------- t = num/den
   logic                 t_valid;
   logic [T_BITS-1:0]    t_quot;
   logic [$bits(tpay_type)-1:0] t_pay_vec;
   tpay_type             t_pay;

   scr_div #(
      .DW (DENW),
      .QW (T_BITS),
      .PW ($bits(tpay_type))
   ) u_t_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s4_v_ff),
      .in_rem      (s4_num_ff),
      .in_low      ('0),
      .in_divisor  (s4_den_ff),
      .in_payload  (s4_pay_ff),
      .out_valid   (t_valid),
      .out_quot    (t_quot),
      .out_payload (t_pay_vec)
   );

   assign t_pay = tpay_type'(t_pay_vec);

   // ---------------------------------------------------------------- s5: |d|*t
   logic              s5_v_ff;
   mode_type          s5_mode_ff;
   logic [2:0][W-1:0] s5_p_ff, s5_a_ff, s5_b_ff;
   logic [2:0]        s5_neg_ff;
   logic [2:0][MW-1:0] s5_m_ff, s5_m_in;
   logic [2:0][W:0]   s5_mag;
   logic [W-1:0]      s5_rs_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_mag[i]  = t_pay.d[i][W] ? (~t_pay.d[i] + (W+1)'(1)) : t_pay.d[i];
         s5_m_in[i] = s5_mag[i] * t_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= t_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_mode_ff <= t_pay.mode;
         s5_p_ff    <= t_pay.p;
         s5_a_ff    <= t_pay.a;
         s5_b_ff    <= t_pay.b;
         s5_neg_ff  <= {t_pay.d[2][W], t_pay.d[1][W], t_pay.d[0][W]};
         s5_m_ff    <= s5_m_in;
         s5_rs_ff   <= t_pay.rs;
      end
   end

   // ---------------------------------------------------------------- s6: closest point
   logic              s6_v_ff;
   logic [2:0][W-1:0] s6_p_ff, s6_q_ff, s6_q_in;
   logic [W-1:0]      s6_rs_ff;
   logic [2:0][MW:0]  s6_rnd;
   logic [2:0][W+1:0] s6_off, s6_qt;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // round half away from zero on the magnitude
         s6_rnd[i] = {1'b0, s5_m_ff[i]} + ((MW+1)'(1) << (T_BITS - 1));
         s6_off[i] = {1'b0, s6_rnd[i][MW-1:T_BITS]};
         if (s5_neg_ff[i]) begin
            s6_off[i] = ~s6_off[i] + (W+2)'(1);
         end
         s6_qt[i] = {{2{s5_a_ff[i][W-1]}}, s5_a_ff[i]} + s6_off[i];
         case (s5_mode_ff)
            MODE_B:  s6_q_in[i] = s5_b_ff[i];
            MODE_T:  s6_q_in[i] = s6_qt[i][W-1:0];
            default: s6_q_in[i] = s5_a_ff[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_p_ff  <= s5_p_ff;
         s6_q_ff  <= s6_q_in;
         s6_rs_ff <= s5_rs_ff;
      end
   end

   // ---------------------------------------------------------------- s7: P-Q
   logic              s7_v_ff;
   logic [2:0][W-1:0] s7_p_ff;
   logic [2:0][W:0]   s7_diff_ff, s7_diff_in;
   logic [W-1:0]      s7_rs_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_diff_in[i] = {s6_p_ff[i][W-1], s6_p_ff[i]} - {s6_q_ff[i][W-1], s6_q_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_p_ff    <= s6_p_ff;
         s7_diff_ff <= s7_diff_in;
         s7_rs_ff   <= s6_rs_ff;
      end
   end

   // ---------------------------------------------------------------- s8: squares
   logic                s8_v_ff;
   logic [2:0][W-1:0]   s8_p_ff;
   logic [2:0][W:0]     s8_diff_ff;
   logic [2:0][DENW-1:0] s8_sq_ff, s8_sq_in;
   logic [2*W-1:0]      s8_rs2_ff, s8_rs2_in;
   logic [W-1:0]        s8_rs_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s8_sq_in[i] = $signed(s7_diff_ff[i]) * $signed(s7_diff_ff[i]);
      end
      s8_rs2_in = s7_rs_ff * s7_rs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_v_ff <= 1'b0;
      end else if (adv) begin
         s8_v_ff <= s7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_p_ff    <= s7_p_ff;
         s8_diff_ff <= s7_diff_ff;
         s8_sq_ff   <= s8_sq_in;
         s8_rs2_ff  <= s8_rs2_in;
         s8_rs_ff   <= s7_rs_ff;
      end
   end

   // ---------------------------------------------------------------- s9: |P-Q|^2
   logic              s9_v_ff;
   logic [2:0][W-1:0] s9_p_ff;
   logic [2:0][W:0]   s9_diff_ff;
   logic [DENW-1:0]   s9_sq_ff, s9_sq_in;
   logic [2*W-1:0]    s9_rs2_ff;
   logic [W-1:0]      s9_rs_ff;
   spay_type          s9_pay;

   assign s9_sq_in = s8_sq_ff[0] + s8_sq_ff[1] + s8_sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_v_ff <= 1'b0;
      end else if (adv) begin
         s9_v_ff <= s8_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_p_ff    <= s8_p_ff;
         s9_diff_ff <= s8_diff_ff;
         s9_sq_ff   <= s9_sq_in;
         s9_rs2_ff  <= s8_rs2_ff;
         s9_rs_ff   <= s8_rs_ff;
      end
   end

   // touching counts as a hit
   always_comb begin
      s9_pay.hit  = (s9_sq_ff <= {2'b00, s9_rs2_ff});
      s9_pay.zero = (s9_sq_ff == '0);
      s9_pay.p    = s9_p_ff;
      s9_pay.diff = {s9_diff_ff[1], s9_diff_ff[0]};
      s9_pay.rs   = s9_rs_ff;
   end

   // ---------------------------------------------------------------- distance
   logic                        r_valid;
   logic [RW-1:0]               r_root;
   logic [$bits(spay_type)-1:0] r_pay_vec;
   spay_type                    r_pay;

   scr_sqrt #(
      .NW (DENW),
      .RW (RW),
      .PW ($bits(spay_type))
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s9_v_ff),
      .in_rad      (s9_sq_ff),
      .in_payload  (s9_pay),
      .out_valid   (r_valid),
      .out_root    (r_root),
      .out_payload (r_pay_vec)
   );

   assign r_pay = spay_type'(r_pay_vec);

   // ---------------------------------------------------------------- s11: |diff|*depth
   logic                s11_v_ff;
   logic                s11_hit_ff, s11_zero_ff;
   logic [2:0][W-1:0]   s11_p_ff;
   logic [1:0]          s11_neg_ff;
   logic [1:0][2*W:0]   s11_n_ff, s11_n_in;
   logic [1:0][W:0]     s11_mag;
   logic [RW-1:0]       s11_root_ff;
   logic [W-1:0]        s11_rs_ff;
   logic [W-1:0]        s11_pen;

   always_comb begin
      // depth is only meaningful on a hit, where the root never exceeds rs
      s11_pen = r_pay.rs - r_root[W-1:0];
      for (int i = 0; i < 2; i++) begin
         s11_mag[i] = r_pay.diff[i][W] ? (~r_pay.diff[i] + (W+1)'(1)) : r_pay.diff[i];
         s11_n_in[i] = s11_mag[i] * s11_pen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_v_ff <= 1'b0;
      end else if (adv) begin
         s11_v_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s11_hit_ff  <= r_pay.hit;
         s11_zero_ff <= r_pay.zero;
         s11_p_ff    <= r_pay.p;
         s11_neg_ff  <= {r_pay.diff[1][W], r_pay.diff[0][W]};
         s11_n_ff    <= s11_n_in;
         s11_root_ff <= r_root;
         s11_rs_ff   <= r_pay.rs;
      end
   end

   // ---------------------------------------------------------------- correction divide
   logic [1:0][2*W+1:0] cd_num;
   cpay_type            cd_pay_in;
   logic                cx_valid, cy_valid;
   logic [RW-1:0]       cx_quot, cy_quot;
   logic [$bits(cpay_type)-1:0] cx_pay_vec;
   cpay_type            cx_pay;
   logic                cy_neg;

   always_comb begin
      // add half the divisor for rounding to nearest
      for (int i = 0; i < 2; i++) begin
         cd_num[i] = {1'b0, s11_n_ff[i]} + {{(W+1){1'b0}}, s11_root_ff >> 1};
      end
      cd_pay_in.hit   = s11_hit_ff;
      cd_pay_in.zero  = s11_zero_ff;
      cd_pay_in.p     = s11_p_ff;
      cd_pay_in.neg_x = s11_neg_ff[0];
      cd_pay_in.rs    = s11_rs_ff;
   end

   scr_div #(
      .DW (RW),
      .QW (RW),
      .PW ($bits(cpay_type))
   ) u_cx_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s11_v_ff),
      .in_rem      (cd_num[0][2*W+1:W+1]),
      .in_low      (cd_num[0][W:0]),
      .in_divisor  (s11_root_ff),
      .in_payload  (cd_pay_in),
      .out_valid   (cx_valid),
      .out_quot    (cx_quot),
      .out_payload (cx_pay_vec)
   );

   scr_div #(
      .DW (RW),
      .QW (RW),
      .PW (1)
   ) u_cy_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s11_v_ff),
      .in_rem      (cd_num[1][2*W+1:W+1]),
      .in_low      (cd_num[1][W:0]),
      .in_divisor  (s11_root_ff),
      .in_payload  (s11_neg_ff[1]),
      .out_valid   (cy_valid),
      .out_quot    (cy_quot),
      .out_payload (cy_neg)
   );

   assign cx_pay = cpay_type'(cx_pay_vec);

   // ---------------------------------------------------------------- output register
   logic         rsp_hit_ff;
   logic [W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [W-1:0] out_x_in, out_y_in;

   always_comb begin
      out_x_in = cx_pay.p[0];
      out_y_in = cx_pay.p[1];
      if (cx_pay.hit) begin
         if (cx_pay.zero) begin
            // centre on the segment: push along +x by the full radius sum
            out_x_in = sat_add(cx_pay.p[0], {1'b0, cx_pay.rs}, 1'b0);
         end else begin
            out_x_in = sat_add(cx_pay.p[0], cx_quot, cx_pay.neg_x);
            out_y_in = sat_add(cx_pay.p[1], cy_quot, cy_neg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         // both dividers run in lock step
         rsp_valid_ff <= cx_valid && cy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= cx_pay.hit;
         rsp_x_ff   <= out_x_in;
         rsp_y_ff   <= out_y_in;
         rsp_z_ff   <= cx_pay.p[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_out_z = rsp_z_ff;

endmodule
`default_nettype wire
